### rtl/core/tss_pkg.sv
// Package for the tracker song sequencer: item structs, codes and constants.
// It also holds the helper functions for position stepping and status ranking.
// It depends on nothing else.
`default_nettype none

package tss_pkg;

	localparam int MAX_POSITIONS    = 128;
	localparam int ROWS_PER_PATTERN = 64;
	localparam int PA_W             = $clog2(MAX_POSITIONS);

	localparam int POS_W   = 8;
	localparam int ROW_W   = 6;
	localparam int PAT_W   = 7;
	localparam int SPEED_W = 5;
	localparam int FINE_W  = 8;
	localparam int CFG_W   = 8;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_ORDER = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	localparam int FX_SPEED = 0;
	localparam int FX_FINE  = 1;
	localparam int FX_LOOP  = 2;
	localparam int FX_JUMP  = 3;
	localparam int FX_SKIP  = 4;
	localparam int FX_LOAD  = 5;

	localparam logic [1:0] ST_NONE  = 2'd0;
	localparam logic [1:0] ST_ENDED = 2'd1;
	localparam logic [1:0] ST_UNREC = 2'd2;

	localparam logic [1:0] CFG_SONG_LENGTH       = 2'd0;
	localparam logic [1:0] CFG_PATTERN_COUNT     = 2'd1;
	localparam logic [1:0] CFG_DEFAULT_SPEED     = 2'd2;
	localparam logic [1:0] CFG_DEFAULT_FINESPEED = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] effect_flags;
		logic [4:0] set_speed;
		logic [7:0] set_finespeed;
		logic [6:0] new_position;
		logic [5:0] new_row;
		logic [5:0] loop_start_row;
		logic [7:0] loop_count;
		logic [6:0] order_value;
	} tss_req_t;

	typedef struct packed {
		logic [6:0] position;
		logic [6:0] pattern_number;
		logic [5:0] row;
		logic       row_advanced;
		logic [4:0] speed;
		logic [7:0] finespeed;
		logic [1:0] status;
	} tss_rsp_t;

	// Position that follows pos, wrapping to zero at the song length.
	function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] pos,
			input logic [CFG_W-1:0] len);
		logic [POS_W:0] p1;
		p1 = {1'b0, pos} + (POS_W+1)'(1);
		if (p1 >= {1'b0, len}) begin
			return '0;
		end
		return p1[POS_W-1:0];
	endfunction

	// Status only rises: unrecoverable outranks ended.
	function automatic logic [1:0] raise_status(input logic [1:0] cur, input logic [1:0] s);
		return (s > cur) ? s : cur;
	endfunction

endpackage

`default_nettype wire

### rtl/core/tracker_song_sequencer.sv
// Tracker song sequencer: walks the order table, applies tempo, loop, jump and skip effects.
// An item goes through the work and result registers; one item per cycle unless stalled.
// The order table is read through two registered ports as an item enters the work register.
// Reset loads the register defaults and the play state; the order table holds no reset value.
// Depends on tss_pkg.
`default_nettype none

module tracker_song_sequencer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire tss_pkg::tss_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output tss_pkg::tss_rsp_t      rsp,
	input  wire logic              cfg_write,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data
);
	import tss_pkg::*;

	logic [CFG_W-1:0]   song_length_q;
	logic [CFG_W-1:0]   pattern_count_q;
	logic [SPEED_W-1:0] default_speed_q;
	logic [FINE_W-1:0]  default_fine_q;

	logic [PAT_W-1:0] order_mem [MAX_POSITIONS];

	logic                     s1_valid_q;
	tss_req_t                 req_s1;
	logic [PAT_W-1:0]         rd_a_s1;
	logic [PAT_W-1:0]         rd_b_s1;

	logic [POS_W-1:0]         pos_q;
	logic [PAT_W-1:0]         pat_q;
	logic [ROW_W-1:0]         row_q;
	logic [SPEED_W-1:0]       tick_q;
	logic [SPEED_W-1:0]       speed_q;
	logic [FINE_W-1:0]        fine_q;
	logic [ROW_W-1:0]         loop_row_q;
	logic [7:0]               loop_left_q;
	logic [1:0]               status_q;
	logic [MAX_POSITIONS-1:0] visited_q;

	logic                     rsp_valid_q;
	tss_rsp_t                 rsp_q;

	logic                     s1_fire;
	logic                     req_accept;
	logic [POS_W-1:0]         pos_after;
	logic [POS_W-1:0]         rd_b_addr;

	logic [POS_W-1:0]         pos_n;
	logic [PAT_W-1:0]         pat_n;
	logic [ROW_W-1:0]         row_n;
	logic [SPEED_W-1:0]       tick_n;
	logic [SPEED_W-1:0]       speed_n;
	logic [FINE_W-1:0]        fine_n;
	logic [ROW_W-1:0]         loop_row_n;
	logic [7:0]               loop_left_n;
	logic [1:0]               status_n;
	logic [MAX_POSITIONS-1:0] visited_n;
	logic                     adv_n;
	logic                     ended_hit;

	assign s1_fire    = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall  = s1_valid_q && !s1_fire;
	assign req_accept = req_valid && !req_stall;
	assign pos_after  = s1_fire ? pos_n : pos_q;
	assign rd_b_addr  = next_pos(pos_after, song_length_q);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			song_length_q   <= CFG_W'(1);
			pattern_count_q <= CFG_W'(1);
			default_speed_q <= SPEED_W'(6);
			default_fine_q  <= FINE_W'(125);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SONG_LENGTH:       song_length_q   <= cfg_data;
				CFG_PATTERN_COUNT:     pattern_count_q <= cfg_data;
				CFG_DEFAULT_SPEED:     default_speed_q <= cfg_data[SPEED_W-1:0];
				CFG_DEFAULT_FINESPEED: default_fine_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Port A serves start and jump targets, port B the position after the current one.
	always_ff @(posedge clk) begin
		if (req_accept) begin
			if (req.kind == KIND_ORDER && {1'b0, req.new_position} < (PAT_W+1)'(MAX_POSITIONS)) begin
				order_mem[PA_W'(req.new_position)] <= req.order_value;
			end
			rd_a_s1 <= order_mem[PA_W'(req.new_position)];
			rd_b_s1 <= order_mem[rd_b_addr[PA_W-1:0]];
			req_s1  <= req;
		end
	end

	always_comb begin
		logic             do_enter;
		logic [POS_W-1:0] enter_pos;
		logic [PAT_W-1:0] enter_data;
		logic [1:0]       status_base;
		logic [MAX_POSITIONS-1:0] vis_base;
		logic [7:0]       left_eff;
		logic [7:0]       left_dec;
		logic [SPEED_W:0] tick_inc;
		logic [ROW_W:0]   row_inc;
		logic             looped;

		pos_n       = pos_q;
		pat_n       = pat_q;
		row_n       = row_q;
		tick_n      = tick_q;
		speed_n     = speed_q;
		fine_n      = fine_q;
		loop_row_n  = loop_row_q;
		loop_left_n = loop_left_q;
		adv_n       = 1'b0;
		do_enter    = 1'b0;
		enter_pos   = pos_q;
		enter_data  = rd_a_s1;
		status_base = status_q;
		vis_base    = visited_q;
		left_eff    = loop_left_q;
		left_dec    = loop_left_q;
		tick_inc    = {1'b0, tick_q} + (SPEED_W+1)'(1);
		row_inc     = {1'b0, row_q} + (ROW_W+1)'(1);
		looped      = 1'b0;

		case (req_s1.kind)
			KIND_START: begin
				pos_n       = POS_W'(req_s1.new_position);
				loop_row_n  = '0;
				loop_left_n = '0;
				vis_base    = '0;
				row_n       = '0;
				tick_n      = '0;
				speed_n     = default_speed_q;
				fine_n      = default_fine_q;
				status_base = ST_NONE;
				do_enter    = 1'b1;
				enter_pos   = pos_n;
				enter_data  = rd_a_s1;
			end
			KIND_TICK: begin
				if (req_s1.effect_flags[FX_SPEED] && req_s1.effect_flags[FX_FINE]) begin
					speed_n = req_s1.set_speed;
					fine_n  = req_s1.set_finespeed;
				end else if (req_s1.effect_flags[FX_FINE]) begin
					fine_n = req_s1.set_finespeed;
				end else if (req_s1.effect_flags[FX_SPEED]) begin
					speed_n = req_s1.set_speed;
					fine_n  = default_fine_q;
				end
				if (req_s1.effect_flags[FX_LOAD]) begin
					loop_row_n = req_s1.loop_start_row;
					left_eff   = req_s1.loop_count;
				end
				loop_left_n = left_eff;
				if (tick_inc >= {1'b0, speed_n}) begin
					tick_n = '0;
					adv_n  = 1'b1;
					if (req_s1.effect_flags[FX_LOOP]) begin
						left_dec    = (left_eff != '0) ? left_eff - 8'd1 : '0;
						loop_left_n = left_dec;
						looped      = (left_dec != '0);
					end
					if (looped) begin
						row_n = loop_row_n;
					end else if (req_s1.effect_flags[FX_JUMP]) begin
						pos_n      = POS_W'(req_s1.new_position);
						do_enter   = 1'b1;
						enter_pos  = pos_n;
						enter_data = rd_a_s1;
						row_n      = '0;
					end else if (req_s1.effect_flags[FX_SKIP]) begin
						pos_n      = next_pos(pos_q, song_length_q);
						do_enter   = 1'b1;
						enter_pos  = pos_n;
						enter_data = rd_b_s1;
						row_n      = req_s1.new_row;
					end else if (row_inc >= (ROW_W+1)'(ROWS_PER_PATTERN)) begin
						pos_n      = next_pos(pos_q, song_length_q);
						do_enter   = 1'b1;
						enter_pos  = pos_n;
						enter_data = rd_b_s1;
						row_n      = '0;
					end else begin
						row_n = row_inc[ROW_W-1:0];
					end
				end else begin
					tick_n = tick_inc[SPEED_W-1:0];
				end
			end
			default: ;
		endcase

		status_n  = status_base;
		visited_n = vis_base;
		ended_hit = 1'b0;
		if (do_enter) begin
			if ({1'b0, enter_pos} >= (POS_W+1)'(song_length_q)
					|| {1'b0, enter_pos} >= (POS_W+1)'(MAX_POSITIONS)) begin
				status_n = raise_status(status_n, ST_UNREC);
			end else begin
				if (vis_base[enter_pos[PA_W-1:0]]) begin
					ended_hit = 1'b1;
					status_n  = raise_status(status_n, ST_ENDED);
					visited_n = '0;
				end else begin
					visited_n[enter_pos[PA_W-1:0]] = 1'b1;
				end
				if ({1'b0, enter_data} >= pattern_count_q) begin
					status_n = raise_status(status_n, ST_UNREC);
				end else begin
					pat_n = enter_data;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			pos_q       <= '0;
			pat_q       <= '0;
			row_q       <= '0;
			tick_q      <= '0;
			speed_q     <= SPEED_W'(6);
			fine_q      <= FINE_W'(125);
			loop_row_q  <= '0;
			loop_left_q <= '0;
			status_q    <= ST_NONE;
			visited_q   <= '0;
		end else begin
			if (req_accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				pos_q       <= pos_n;
				pat_q       <= pat_n;
				row_q       <= row_n;
				tick_q      <= tick_n;
				speed_q     <= speed_n;
				fine_q      <= fine_n;
				loop_row_q  <= loop_row_n;
				loop_left_q <= loop_left_n;
				status_q    <= status_n;
				visited_q   <= visited_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			rsp_q.position       <= pos_n[6:0];
			rsp_q.pattern_number <= pat_n;
			rsp_q.row            <= row_n;
			rsp_q.row_advanced   <= adv_n;
			rsp_q.speed          <= speed_n;
			rsp_q.finespeed      <= fine_n;
			rsp_q.status         <= status_n;
		end
	end

`ifndef SYNTHESIS
	// A held item keeps its fields and its order-table data.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_fire |=> s1_valid_q && $stable(req_s1) && $stable(rd_a_s1)
			&& $stable(rd_b_s1))
		else $error("work register changed while held");

	// Only a start item may lower the status.
	a_status_rise: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && req_s1.kind != KIND_START |=> status_q >= $past(status_q))
		else $error("status fell without a start item");

	// A revisited position clears every mark and leaves itself unmarked.
	a_marks_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && ended_hit |=> $countones(visited_q) == 0)
		else $error("marks not cleared after a revisit");

	// Every committed item shows up as a result in the next cycle.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> rsp_valid_q && rsp_q.status == status_q)
		else $error("committed item produced no matching result");

	// A wrapped tick leaves the tick counter at zero.
	a_wrap_tick: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && adv_n |=> tick_q == '0 && rsp_q.row_advanced)
		else $error("tick counter not cleared on wrap");
`endif

endmodule

`default_nettype wire

### tb/tracker_song_sequencer_tb.sv
// Self-checking testbench for the tracker song sequencer: a queued driver, a monitor and a
// item-level predictor of the play state, checked item by item over several register settings.
// Depends on tss_pkg and tracker_song_sequencer.
`default_nettype none

module tracker_song_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tss_pkg::*;

	localparam logic [1:0] KIND_IDLE = 2'd3;

	localparam logic [5:0] SPEED_REQ = 6'd1 << FX_SPEED;
	localparam logic [5:0] FINE_REQ  = 6'd1 << FX_FINE;
	localparam logic [5:0] LOOP_REQ  = 6'd1 << FX_LOOP;
	localparam logic [5:0] JUMP_REQ  = 6'd1 << FX_JUMP;
	localparam logic [5:0] SKIP_REQ  = 6'd1 << FX_SKIP;
	localparam logic [5:0] LOAD_REQ  = 6'd1 << FX_LOAD;

	localparam int PHASES      = 6;
	localparam int IDLE_MARGIN = 8;
	localparam int CYCLE_LIMIT = 1000000;

	logic       clk;
	logic       arst_n;
	logic       req_valid = 1'b0;
	logic       req_stall;
	tss_req_t   req = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	tss_rsp_t   rsp;
	logic       cfg_write;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	tss_req_t song_cmds[$];
	tss_rsp_t play_expected[$];

	logic [7:0] cfg_len = 8'd1;
	logic [7:0] cfg_patterns = 8'd1;
	logic [4:0] cfg_speed = 5'd6;
	logic [7:0] cfg_fine = 8'd125;

	logic [6:0]               order_mem [MAX_POSITIONS];
	logic [MAX_POSITIONS-1:0] visited_marks = '0;
	logic [7:0]               play_pos = '0;
	logic [6:0]               play_pattern = '0;
	logic [6:0]               play_row = '0;
	logic [5:0]               tick_cnt = '0;
	logic [4:0]               play_speed = 5'd6;
	logic [7:0]               play_fine = 8'd125;
	logic [5:0]               loop_row_reg = '0;
	logic [7:0]               loop_left_reg = '0;
	logic [1:0]               play_status = ST_NONE;

	int   send_gap = 0;
	int   send_calm = 0;
	int   stall_left = 0;
	int   recv_calm = 0;
	logic hold_off = 1'b0;
	int   phase_num = -1;
	int   mismatch_count = 0;
	int   cycle_count = 0;

	tracker_song_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic bit chance(input int percent);
		return $urandom_range(0, 99) < percent;
	endfunction

	function automatic int draw_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end else if (roll < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic void bump_status(input logic [1:0] level);
		if (level > play_status) begin
			play_status = level;
		end
	endfunction

	function automatic void enter_slot();
		logic [6:0] pat;
		if (play_pos >= cfg_len || play_pos >= MAX_POSITIONS) begin
			bump_status(ST_UNREC);
			return;
		end
		if (visited_marks[play_pos[6:0]]) begin
			bump_status(ST_ENDED);
			visited_marks = '0;
		end else begin
			visited_marks[play_pos[6:0]] = 1'b1;
		end
		pat = order_mem[play_pos[6:0]];
		if ({1'b0, pat} >= cfg_patterns) begin
			bump_status(ST_UNREC);
			return;
		end
		play_pattern = pat;
	endfunction

	function automatic void next_slot();
		play_pos = play_pos + 8'd1;
		if (play_pos >= cfg_len) begin
			play_pos = '0;
		end
		enter_slot();
		play_row = '0;
	endfunction

	function automatic tss_rsp_t advance_song(input tss_req_t r);
		tss_rsp_t res;
		logic     wrapped;
		logic     looped;
		wrapped = 1'b0;
		looped = 1'b0;
		case (r.kind)
			KIND_ORDER: begin
				order_mem[r.new_position] = r.order_value;
			end
			KIND_START: begin
				play_pos = {1'b0, r.new_position};
				loop_row_reg = '0;
				loop_left_reg = '0;
				visited_marks = '0;
				play_row = '0;
				tick_cnt = '0;
				play_speed = cfg_speed;
				play_fine = cfg_fine;
				play_status = ST_NONE;
				enter_slot();
			end
			KIND_TICK: begin
				if (r.effect_flags[FX_SPEED] && r.effect_flags[FX_FINE]) begin
					play_speed = r.set_speed;
					play_fine = r.set_finespeed;
				end else if (r.effect_flags[FX_FINE]) begin
					play_fine = r.set_finespeed;
				end else if (r.effect_flags[FX_SPEED]) begin
					play_speed = r.set_speed;
					play_fine = cfg_fine;
				end
				if (r.effect_flags[FX_LOAD]) begin
					loop_row_reg = r.loop_start_row;
					loop_left_reg = r.loop_count;
				end
				tick_cnt = tick_cnt + 6'd1;
				if (tick_cnt >= {1'b0, play_speed}) begin
					tick_cnt = '0;
					wrapped = 1'b1;
					if (r.effect_flags[FX_LOOP]) begin
						if (loop_left_reg != 0) begin
							loop_left_reg = loop_left_reg - 8'd1;
						end
						looped = (loop_left_reg != 0);
					end
					if (looped) begin
						play_row = {1'b0, loop_row_reg};
					end else if (r.effect_flags[FX_JUMP]) begin
						play_pos = {1'b0, r.new_position};
						enter_slot();
						play_row = '0;
					end else if (r.effect_flags[FX_SKIP]) begin
						next_slot();
						play_row = {1'b0, r.new_row};
					end else begin
						play_row = play_row + 7'd1;
						if (play_row >= ROWS_PER_PATTERN) begin
							next_slot();
						end
					end
				end
			end
			default: begin
			end
		endcase
		res.position = play_pos[6:0];
		res.pattern_number = play_pattern;
		res.row = play_row[5:0];
		res.row_advanced = wrapped;
		res.speed = play_speed;
		res.finespeed = play_fine;
		res.status = play_status;
		return res;
	endfunction

	function automatic tss_req_t random_req();
		logic [63:0] bits;
		tss_req_t    r;
		bits = {$urandom, $urandom};
		r = bits[$bits(tss_req_t)-1:0];
		r.set_finespeed = 8'($urandom_range(32, 255));
		return r;
	endfunction

	function automatic tss_req_t song_item(input logic [1:0] kind, input logic [6:0] pos,
			input logic [6:0] value);
		tss_req_t r;
		r = random_req();
		r.kind = kind;
		r.new_position = pos;
		r.order_value = value;
		return r;
	endfunction

	function automatic tss_req_t tick_item(input logic [5:0] fx, input logic [4:0] spd,
			input logic [7:0] fine, input logic [6:0] pos, input logic [5:0] nrow,
			input logic [5:0] lrow, input logic [7:0] lcnt);
		tss_req_t r;
		r = random_req();
		r.kind = KIND_TICK;
		r.effect_flags = fx;
		r.set_speed = spd;
		r.set_finespeed = fine;
		r.new_position = pos;
		r.new_row = nrow;
		r.loop_start_row = lrow;
		r.loop_count = lcnt;
		return r;
	endfunction

	function automatic tss_req_t random_tick();
		tss_req_t r;
		r = random_req();
		r.kind = KIND_TICK;
		r.effect_flags = '0;
		r.effect_flags[FX_SPEED] = chance(12);
		r.effect_flags[FX_FINE] = chance(10);
		r.effect_flags[FX_LOOP] = chance(20);
		r.effect_flags[FX_JUMP] = chance(6);
		r.effect_flags[FX_SKIP] = chance(10);
		r.effect_flags[FX_LOAD] = chance(10);
		r.set_speed = chance(80) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
		if (chance(75)) begin
			r.new_position = 7'($urandom_range(0, int'(cfg_len) - 1));
		end
		if (chance(70)) begin
			r.loop_count = 8'($urandom_range(0, 4));
		end
		return r;
	endfunction

	function automatic tss_req_t random_song_item();
		int         roll;
		logic [6:0] pos;
		logic [6:0] value;
		roll = $urandom_range(0, 99);
		if (roll < 80) begin
			return random_tick();
		end else if (roll < 89) begin
			value = chance(70) ? 7'($urandom_range(0, int'(cfg_patterns) - 1))
				: 7'($urandom_range(0, 127));
			return song_item(KIND_ORDER, 7'($urandom_range(0, 127)), value);
		end else if (roll < 98) begin
			pos = chance(85) ? 7'($urandom_range(0, int'(cfg_len) - 1))
				: 7'($urandom_range(0, 127));
			return song_item(KIND_START, pos, 7'($urandom_range(0, 127)));
		end
		return song_item(KIND_IDLE, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic set_register(input logic [1:0] index, input logic [7:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		case (index)
			CFG_SONG_LENGTH:       cfg_len = value;
			CFG_PATTERN_COUNT:     cfg_patterns = value;
			CFG_DEFAULT_SPEED:     cfg_speed = value[4:0];
			CFG_DEFAULT_FINESPEED: cfg_fine = value;
			default: begin
			end
		endcase
	endtask

	task automatic settle();
		do begin
			@(negedge clk);
		end while (song_cmds.size() != 0 || req_valid || play_expected.size() != 0);
		repeat (IDLE_MARGIN) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				play_expected.push_back(advance_song(req));
			end
			if (req_valid && req_stall) begin
				req_valid <= 1'b1;
			end else if (send_gap > 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (song_cmds.size() != 0) begin
				req <= song_cmds.pop_front();
				req_valid <= 1'b1;
				if (send_calm > 0) begin
					send_calm--;
				end else begin
					send_gap = draw_gap();
					if (chance(2)) begin
						send_calm = $urandom_range(20, 80);
					end
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		tss_rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (play_expected.size() == 0) begin
					$error("result arrived with no item outstanding: %p", rsp);
					mismatch_count++;
				end else begin
					want = play_expected.pop_front();
					check_field("position", 8'(want.position), 8'(rsp.position));
					check_field("pattern_number", 8'(want.pattern_number),
						8'(rsp.pattern_number));
					check_field("row", 8'(want.row), 8'(rsp.row));
					check_field("row_advanced", 8'(want.row_advanced), 8'(rsp.row_advanced));
					check_field("speed", 8'(want.speed), 8'(rsp.speed));
					check_field("finespeed", want.finespeed, rsp.finespeed);
					check_field("status", 8'(want.status), 8'(rsp.status));
				end
			end
			if (hold_off) begin
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				if (recv_calm > 0) begin
					recv_calm--;
				end else begin
					if (chance(30)) begin
						stall_left = draw_gap();
					end
					if (chance(1)) begin
						recv_calm = $urandom_range(20, 100);
					end
				end
			end
		end
	end

	// Long receiver hold-off while the sender keeps offering items.
	initial begin
		wait (phase_num == 3);
		repeat (20) @(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		int item_total;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_SONG_LENGTH;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: begin
					set_register(CFG_SONG_LENGTH, 8'd3);
					set_register(CFG_PATTERN_COUNT, 8'd64);
					set_register(CFG_DEFAULT_SPEED, 8'd0);
					set_register(CFG_DEFAULT_FINESPEED, 8'd200);
				end
				1: begin
					set_register(CFG_SONG_LENGTH, 8'd1);
					set_register(CFG_PATTERN_COUNT, 8'd1);
					set_register(CFG_DEFAULT_SPEED, 8'd0);
					set_register(CFG_DEFAULT_FINESPEED, 8'd32);
				end
				2: begin
					set_register(CFG_SONG_LENGTH, 8'd128);
					set_register(CFG_PATTERN_COUNT, 8'd128);
					set_register(CFG_DEFAULT_SPEED, 8'd31);
					set_register(CFG_DEFAULT_FINESPEED, 8'd255);
				end
				3: begin
					set_register(CFG_SONG_LENGTH, 8'($urandom_range(1, 8)));
					set_register(CFG_PATTERN_COUNT, 8'($urandom_range(1, 128)));
					set_register(CFG_DEFAULT_SPEED, 8'($urandom_range(0, 3)));
					set_register(CFG_DEFAULT_FINESPEED, 8'($urandom_range(32, 255)));
				end
				4: begin
					set_register(CFG_SONG_LENGTH, 8'($urandom_range(1, 128)));
					set_register(CFG_PATTERN_COUNT, 8'($urandom_range(1, 128)));
					set_register(CFG_DEFAULT_SPEED, 8'($urandom_range(0, 31)));
					set_register(CFG_DEFAULT_FINESPEED, 8'($urandom_range(32, 255)));
				end
				default: begin
					set_register(CFG_SONG_LENGTH, 8'($urandom_range(2, 16)));
					set_register(CFG_PATTERN_COUNT, 8'd128);
					set_register(CFG_DEFAULT_SPEED, 8'd1);
					set_register(CFG_DEFAULT_FINESPEED, 8'($urandom_range(32, 255)));
				end
			endcase
			@(posedge clk);
			cfg_write <= 1'b0;
			phase_num = ph;
			@(negedge clk);
			item_total = 315;
			if (ph == 0) begin
				item_total = 250;
				for (int i = 0; i < MAX_POSITIONS; i++) begin
					song_cmds.push_back(song_item(KIND_ORDER, 7'(i), 7'($urandom_range(0, 127))));
				end
				song_cmds.push_back(song_item(KIND_ORDER, 7'd0, 7'd5));
				song_cmds.push_back(song_item(KIND_ORDER, 7'd1, 7'd63));
				song_cmds.push_back(song_item(KIND_ORDER, 7'd2, 7'd64));
				song_cmds.push_back(song_item(KIND_ORDER, 7'd127, 7'd127));
				song_cmds.push_back(song_item(KIND_START, 7'd0, 7'd0));
				song_cmds.push_back(tick_item(SPEED_REQ | FINE_REQ, 5'd2, 8'd32, '0, '0, '0, '0));
				song_cmds.push_back(tick_item(FINE_REQ, 5'd0, 8'd255, '0, '0, '0, '0));
				song_cmds.push_back(tick_item(SPEED_REQ, 5'd0, 8'd255, '0, '0, '0, '0));
				song_cmds.push_back(tick_item(LOAD_REQ | LOOP_REQ, 5'd31, 8'd32, 7'd127,
					6'd63, 6'd63, 8'd255));
				song_cmds.push_back(tick_item(LOOP_REQ, 5'd31, 8'd32, '0, '0, '0, '0));
				song_cmds.push_back(tick_item('0, 5'd31, 8'd32, '0, '0, '0, '0));
				song_cmds.push_back(tick_item(LOAD_REQ | LOOP_REQ, '0, 8'd32, '0, '0, 6'd10,
					8'd1));
				song_cmds.push_back(tick_item(LOOP_REQ, '0, 8'd32, '0, '0, '0, '0));
				song_cmds.push_back(tick_item(LOAD_REQ | LOOP_REQ | JUMP_REQ | SKIP_REQ, '0,
					8'd32, 7'd0, 6'd5, 6'd7, 8'd3));
				song_cmds.push_back(tick_item(JUMP_REQ, '0, 8'd32, 7'd127, '0, '0, '0));
				song_cmds.push_back(song_item(KIND_START, 7'd1, 7'd0));
				song_cmds.push_back(tick_item(SKIP_REQ, '0, 8'd32, '0, 6'd63, '0, '0));
				song_cmds.push_back(song_item(KIND_START, 7'd0, 7'd0));
				song_cmds.push_back(tick_item(JUMP_REQ | SKIP_REQ, '0, 8'd32, 7'd0, 6'd9, '0,
					'0));
				song_cmds.push_back(tick_item(SPEED_REQ, 5'd31, 8'd32, '0, '0, '0, '0));
				song_cmds.push_back(tick_item(SPEED_REQ | FINE_REQ, 5'd0, 8'd32, '0, '0, '0,
					'0));
				song_cmds.push_back(song_item(KIND_IDLE, 7'd5, 7'd5));
				song_cmds.push_back(song_item(KIND_START, 7'd127, 7'd0));
				song_cmds.push_back(tick_item(SKIP_REQ, '0, 8'd32, '0, 6'd0, '0, '0));
			end
			song_cmds.push_back(song_item(KIND_START, 7'($urandom_range(0, int'(cfg_len) - 1)),
				7'd0));
			for (int i = 0; i < item_total; i++) begin
				song_cmds.push_back(random_song_item());
			end
		end
		settle();
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
rtl/core/tss_pkg.sv
rtl/core/tracker_song_sequencer.sv
tb/tracker_song_sequencer_tb.sv
